### hw/rtl/ikarm_pkg.sv
// Shared types, widths and constants for the two-link arm inverse kinematics block.
// Holds the arctangent table used by the arccos pipeline. Depends on nothing.
package ikarm_pkg;

    localparam int FRAC_BITS = 6;
    localparam int CF_BITS   = 16;
    localparam int ANG_SH    = CF_BITS - FRAC_BITS;
    localparam int PRE_SH    = 8;

    localparam longint ONE   = longint'(1) << FRAC_BITS;
    localparam longint S2    = ONE * ONE;
    localparam longint D180  = 180 * ONE;
    localparam longint Q16   = longint'(1) << CF_BITS;
    localparam longint LIM14 = (D180 < 16383) ? D180 : 16383;
    localparam longint LIM16 = (360 * ONE < 32767) ? 360 * ONE : 32767;

    localparam longint LONG_LO  = 28 * ONE;
    localparam longint LONG_HI  = 40 * ONE;
    localparam longint SHORT_LO = 25 * ONE / 2;

    localparam longint C0L_NUM = 802 * S2;
    localparam longint C0L_DEN = 798 * S2;
    localparam longint C0S_NUM = 5821169 * S2;
    localparam longint C0S_DEN = 5650600 * S2;
    localparam longint C1L_ADD = 80 * S2;
    localparam longint C1L_DK  = 42 * ONE;
    localparam longint C1S_SUB = 1398831 * S2;
    localparam longint C1S_DK  = 297400 * ONE;
    localparam longint C2_SUB  = 14196 * S2;
    localparam longint C2_DK   = 2960 * ONE;
    localparam longint C423    = (423 * ONE + 5) / 10;
    localparam longint C477    = (477 * ONE + 5) / 10;

    localparam int REACH_W = 12;
    localparam int BASE_W  = 15;
    localparam int OFS_W   = 15;
    localparam int J1_W    = 14;
    localparam int J2_W    = 16;
    localparam int J3_W    = 14;
    localparam int J4_W    = 16;
    localparam int ST_W    = 2;
    localparam int ZZ_W    = 2 * REACH_W;
    localparam int NUM_W   = 38;
    localparam int DEN_W   = 36;
    localparam int QUO_W   = 18;
    localparam int C_W     = 18;
    localparam int SQ_W    = 34;
    localparam int ROOT_N  = 17;
    localparam int CX_W    = 28;
    localparam int CORDIC_N = 16;
    localparam int ANG_W   = 14;

    localparam int DIV_LAT  = QUO_W + 3;
    localparam int ACOS_LAT = ROOT_N + CORDIC_N + 3;
    localparam int SIDE_LAT = DIV_LAT + ACOS_LAT;

    localparam logic [ST_W-1:0] ST_LONG    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [ST_W-1:0] ST_UNREACH = 2'd3;

    typedef struct packed {
        logic                    long_b;
        logic                    short_b;
        logic                    mir;
        logic [J1_W-1:0]         j1;
        logic signed [OFS_W-1:0] ofs;
    } side_t;

    function automatic logic [23:0] atan_q16(input int idx);
        logic [23:0] v;
        case (idx)
            0:       v = 24'd2949120;
            1:       v = 24'd1740967;
            2:       v = 24'd919879;
            3:       v = 24'd466945;
            4:       v = 24'd234379;
            5:       v = 24'd117304;
            6:       v = 24'd58666;
            7:       v = 24'd29335;
            8:       v = 24'd14668;
            9:       v = 24'd7334;
            10:      v = 24'd3667;
            11:      v = 24'd1833;
            12:      v = 24'd917;
            13:      v = 24'd458;
            14:      v = 24'd229;
            15:      v = 24'd115;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/ikarm_div.sv
// Pipelined restoring divider that forms a rounded cosine ratio with 16 fraction bits.
// The ratio is clamped to [-1, 1]. Depends on ikarm_pkg.
module ikarm_div (
    input  logic                                clk,
    input  logic signed [ikarm_pkg::NUM_W-1:0]  num,
    input  logic        [ikarm_pkg::DEN_W-1:0]  den,
    output logic signed [ikarm_pkg::C_W-1:0]    c
);
    import ikarm_pkg::*;

    localparam int NP_W = NUM_W + CF_BITS + 1;
    localparam int HI_W = NP_W - QUO_W;

    logic [NUM_W-1:0] mag;
    logic [NP_W-1:0]  np_next;
    logic [NP_W-1:0]  np_reg;
    logic [DEN_W-1:0] den0_reg;
    logic             neg0_reg;
    logic [HI_W-1:0]  hi;

    logic [DEN_W-1:0] rem_reg [0:QUO_W-1];
    logic [QUO_W-1:0] lo_reg  [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];

    logic [CF_BITS:0] qmag;
    logic signed [C_W-1:0] c_reg;

    assign mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign np_next = {1'b0, mag, {CF_BITS{1'b0}}} + NP_W'(den >> 1);
    assign hi      = np_reg[NP_W-1:QUO_W];

    always_ff @(posedge clk)
    begin
        np_reg     <= np_next;
        den0_reg   <= den;
        neg0_reg   <= num[NUM_W-1];
        rem_reg[0] <= hi[DEN_W-1:0];
        lo_reg[0]  <= np_reg[QUO_W-1:0];
        den_reg[0] <= den0_reg;
        quo_reg[0] <= '0;
        neg_reg[0] <= neg0_reg;
        ovf_reg[0] <= (hi >= HI_W'(den0_reg));
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] t;
        logic           ge;
        assign t  = {rem_reg[k], lo_reg[k][QUO_W-1-k]};
        assign ge = (t >= {1'b0, den_reg[k]});
        always_ff @(posedge clk)
        begin
            quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], ge};
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
        if (k < QUO_W - 1) begin : g_pass
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= ge ? DEN_W'(t - {1'b0, den_reg[k]}) : t[DEN_W-1:0];
                lo_reg[k+1]  <= lo_reg[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign qmag = (ovf_reg[QUO_W] || (quo_reg[QUO_W] > QUO_W'(Q16)))
                  ? (CF_BITS+1)'(Q16) : quo_reg[QUO_W][CF_BITS:0];

    always_ff @(posedge clk)
    begin
        c_reg <= neg_reg[QUO_W] ? -$signed(C_W'(qmag)) : $signed(C_W'(qmag));
    end

    assign c = c_reg;

endmodule

### hw/rtl/ikarm_acos.sv
// Pipelined arccos: an integer square root gives the sine, then vectoring CORDIC
// steps give the angle in degrees, rounded to the block's fixed point. Depends on ikarm_pkg.
module ikarm_acos (
    input  logic                              clk,
    input  logic signed [ikarm_pkg::C_W-1:0]  c,
    output logic        [ikarm_pkg::ANG_W-1:0] ang
);
    import ikarm_pkg::*;

    localparam int CA_W = CX_W;

    logic signed [2*C_W-1:0] prod;
    logic [SQ_W-1:0]         sv_reg [0:ROOT_N-1];
    logic [SQ_W-1:0]         sr_reg [0:ROOT_N];
    logic signed [C_W-1:0]   sc_reg [0:ROOT_N];

    logic signed [CX_W-1:0]  cx_reg [0:CORDIC_N-1];
    logic signed [CX_W-1:0]  cy_reg [0:CORDIC_N-1];
    logic signed [CA_W-1:0]  ca_reg [0:CORDIC_N];

    logic signed [CX_W-1:0]  s_e;
    logic signed [CX_W-1:0]  c_e;
    logic signed [CA_W-1:0]  a_cl;
    logic signed [CA_W-1:0]  a_rnd;
    logic [ANG_W-1:0]        ang_reg;

    assign prod = c * c;

    always_ff @(posedge clk)
    begin
        sv_reg[0] <= SQ_W'(Q16 * Q16) - prod[SQ_W-1:0];
        sr_reg[0] <= '0;
        sc_reg[0] <= c;
    end

    for (genvar k = 0; k < ROOT_N; k++) begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_N - 1 - k));
        logic [SQ_W-1:0] t;
        logic            ge;
        assign t  = sr_reg[k] + BIT;
        assign ge = (sv_reg[k] >= t);
        always_ff @(posedge clk)
        begin
            sr_reg[k+1] <= ge ? (sr_reg[k] >> 1) + BIT : sr_reg[k] >> 1;
            sc_reg[k+1] <= sc_reg[k];
        end
        if (k < ROOT_N - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                sv_reg[k+1] <= ge ? sv_reg[k] - t : sv_reg[k];
            end
        end
    end

    assign s_e = $signed(CX_W'(sr_reg[ROOT_N][CF_BITS:0]));
    assign c_e = CX_W'(sc_reg[ROOT_N]);

    always_ff @(posedge clk)
    begin
        if (sc_reg[ROOT_N] < 0)
        begin
            cx_reg[0] <= s_e <<< PRE_SH;
            cy_reg[0] <= (-c_e) <<< PRE_SH;
            ca_reg[0] <= CA_W'(90 * Q16);
        end
        else
        begin
            cx_reg[0] <= c_e <<< PRE_SH;
            cy_reg[0] <= s_e <<< PRE_SH;
            ca_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
        logic signed [CA_W-1:0] at;
        logic                   up;
        assign at = $signed(CA_W'(atan_q16(i)));
        assign up = (cy_reg[i] > 0);
        always_ff @(posedge clk)
        begin
            ca_reg[i+1] <= up ? ca_reg[i] + at : ca_reg[i] - at;
        end
        if (i < CORDIC_N - 1) begin : g_xy
            always_ff @(posedge clk)
            begin
                if (up)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                end
            end
        end
    end

    always_comb
    begin
        if (ca_reg[CORDIC_N] < 0)
            a_cl = '0;
        else if (ca_reg[CORDIC_N] > CA_W'(180 * Q16))
            a_cl = CA_W'(180 * Q16);
        else
            a_cl = ca_reg[CORDIC_N];
        a_rnd = a_cl + CA_W'((longint'(1) << ANG_SH) >> 1);
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ANG_W'(a_rnd >>> ANG_SH);
    end

    assign ang = ang_reg;

endmodule

### hw/rtl/ikarm_pose.sv
// Combines the band, the mirror flag and the three arccos angles into joint angles
// and a status code, with saturation. Depends on ikarm_pkg.
module ikarm_pose (
    input  ikarm_pkg::side_t                    side,
    input  logic        [ikarm_pkg::ANG_W-1:0]  ang0,
    input  logic        [ikarm_pkg::ANG_W-1:0]  ang1,
    input  logic        [ikarm_pkg::ANG_W-1:0]  ang2,
    output logic        [ikarm_pkg::J1_W-1:0]   j1,
    output logic signed [ikarm_pkg::J2_W-1:0]   j2,
    output logic        [ikarm_pkg::J3_W-1:0]   j3,
    output logic signed [ikarm_pkg::J4_W-1:0]   j4,
    output logic        [ikarm_pkg::ST_W-1:0]   st
);
    import ikarm_pkg::*;

    localparam int PW = 18;

    logic signed [PW-1:0] q;
    logic signed [PW-1:0] a0;
    logic signed [PW-1:0] a1;
    logic signed [PW-1:0] a2;
    logic signed [PW-1:0] r2;
    logic signed [PW-1:0] r4;
    logic signed [PW-1:0] c2;
    logic signed [PW-1:0] c4;

    function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] lim;
        lim = PW'(LIM16);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    assign q  = PW'(side.ofs);
    assign a0 = $signed(PW'(ang0));
    assign a1 = $signed(PW'(ang1));
    assign a2 = $signed(PW'(ang2));

    always_comb
    begin
        j1 = side.j1;
        j3 = '0;
        r2 = '0;
        r4 = '0;
        st = ST_RANGE;
        if (side.long_b)
        begin
            st = ST_LONG;
            j3 = J3_W'(90 * ONE);
            if (side.mir)
            begin
                r2 = PW'(D180) - a1 - q;
                r4 = PW'(270 * ONE) - a0;
            end
            else
            begin
                r2 = a1 + q;
                r4 = a0 - PW'(90 * ONE);
            end
        end
        else if (side.short_b)
        begin
            if (q <= PW'(D180 - C423) - a2)
            begin
                st = ST_SHORT;
                if (side.mir)
                begin
                    j3 = '0;
                    r2 = PW'(D180) - (PW'(C423) + a1 + q);
                    r4 = PW'(D180) - (PW'(C477) + a0 - PW'(90 * ONE));
                end
                else
                begin
                    j3 = J3_W'(D180);
                    r2 = PW'(C423) + a1 + q;
                    r4 = PW'(C477) + a0 - PW'(90 * ONE);
                end
            end
            else
            begin
                st = ST_UNREACH;
            end
        end
        else
        begin
            j1 = '0;
        end
    end

    assign c2 = sat(r2);
    assign c4 = sat(r4);
    assign j2 = J2_W'(c2);
    assign j4 = J4_W'(c4);

endmodule

### hw/rtl/two_link_arm_inverse_kinematics.sv
// Top level of the two-link arm inverse kinematics pipeline.
// Uses ikarm_pkg, ikarm_div, ikarm_acos and ikarm_pose.
//
//   Channel   Ports                                        Handshake
//   request   reach, base_angle, wrist_offset              start high, busy low
//   result    joint_one..joint_four, status                done high for one cycle
//
// One transaction enters every cycle; busy stays low because the pipeline never stalls.
// Each result passes through the input and setup stages, a 21-stage divider, a 36-stage
// square root and CORDIC arccos, and the output register. Reset clears only the valid
// bits; results are in request order.
module two_link_arm_inverse_kinematics (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [ikarm_pkg::REACH_W-1:0] reach,
    input  logic        [ikarm_pkg::BASE_W-1:0]  base_angle,
    input  logic signed [ikarm_pkg::OFS_W-1:0]   wrist_offset,
    output logic                                done,
    output logic        [ikarm_pkg::J1_W-1:0]    joint_one,
    output logic signed [ikarm_pkg::J2_W-1:0]    joint_two,
    output logic        [ikarm_pkg::J3_W-1:0]    joint_three,
    output logic signed [ikarm_pkg::J4_W-1:0]    joint_four,
    output logic        [ikarm_pkg::ST_W-1:0]    status
);
    import ikarm_pkg::*;

    logic                     s0_vld_reg;
    logic [REACH_W-1:0]       s0_r_reg;
    logic [BASE_W-1:0]        s0_base_reg;
    logic signed [OFS_W-1:0]  s0_ofs_reg;

    logic                     s1_vld_reg;
    logic [ZZ_W-1:0]          s1_zz_reg;
    logic [REACH_W-1:0]       s1_r_reg;
    side_t                    s1_side_reg;
    logic [ZZ_W-1:0]          zz_next;
    side_t                    side_next;
    logic                     mir;

    logic                     s2_vld_reg;
    side_t                    s2_side_reg;
    logic signed [NUM_W-1:0]  num0_reg;
    logic signed [NUM_W-1:0]  num1_reg;
    logic signed [NUM_W-1:0]  num2_reg;
    logic [DEN_W-1:0]         den0_reg;
    logic [DEN_W-1:0]         den1_reg;
    logic [DEN_W-1:0]         den2_reg;
    logic signed [NUM_W-1:0]  zz_s;
    logic [DEN_W-1:0]         r_d;

    logic [SIDE_LAT-1:0]      vld_dly_reg;
    side_t                    side_dly_reg [0:SIDE_LAT-1];

    logic signed [C_W-1:0]    cos0;
    logic signed [C_W-1:0]    cos1;
    logic signed [C_W-1:0]    cos2;
    logic [ANG_W-1:0]         ang0;
    logic [ANG_W-1:0]         ang1;
    logic [ANG_W-1:0]         ang2;

    logic [J1_W-1:0]          j1;
    logic signed [J2_W-1:0]   j2;
    logic [J3_W-1:0]          j3;
    logic signed [J4_W-1:0]   j4;
    logic [ST_W-1:0]          st;

    logic                     done_reg;
    logic [J1_W-1:0]          joint_one_reg;
    logic signed [J2_W-1:0]   joint_two_reg;
    logic [J3_W-1:0]          joint_three_reg;
    logic signed [J4_W-1:0]   joint_four_reg;
    logic [ST_W-1:0]          status_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            vld_dly_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s0_vld_reg  <= start && !busy;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            vld_dly_reg <= {vld_dly_reg[SIDE_LAT-2:0], s2_vld_reg};
            done_reg    <= vld_dly_reg[SIDE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        s0_r_reg    <= reach;
        s0_base_reg <= base_angle;
        s0_ofs_reg  <= wrist_offset;
    end

    assign zz_next = ZZ_W'(s0_r_reg) * ZZ_W'(s0_r_reg);
    assign mir     = (s0_base_reg > BASE_W'(D180));

    always_comb
    begin
        side_next.long_b  = (s0_r_reg >= REACH_W'(LONG_LO)) && (s0_r_reg <= REACH_W'(LONG_HI));
        side_next.short_b = (s0_r_reg >= REACH_W'(SHORT_LO)) && (s0_r_reg < REACH_W'(LONG_LO));
        side_next.mir     = mir;
        side_next.ofs     = s0_ofs_reg;
        if (mir)
        begin
            if (s0_base_reg - BASE_W'(D180) > BASE_W'(LIM14))
                side_next.j1 = J1_W'(LIM14);
            else
                side_next.j1 = J1_W'(s0_base_reg - BASE_W'(D180));
        end
        else if (s0_base_reg > BASE_W'(LIM14))
        begin
            side_next.j1 = J1_W'(LIM14);
        end
        else
        begin
            side_next.j1 = J1_W'(s0_base_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zz_reg   <= zz_next;
        s1_r_reg    <= s0_r_reg;
        s1_side_reg <= side_next;
    end

    assign zz_s = $signed(NUM_W'(s1_zz_reg));
    assign r_d  = DEN_W'(s1_r_reg);

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s1_side_reg;
        num2_reg    <= NUM_W'(100) * zz_s - NUM_W'(C2_SUB);
        den2_reg    <= DEN_W'(C2_DK) * r_d;
        if (s1_side_reg.long_b)
        begin
            num0_reg <= NUM_W'(C0L_NUM) - zz_s;
            den0_reg <= DEN_W'(C0L_DEN);
            num1_reg <= zz_s + NUM_W'(C1L_ADD);
            den1_reg <= DEN_W'(C1L_DK) * r_d;
        end
        else
        begin
            num0_reg <= NUM_W'(C0S_NUM) - NUM_W'(10000) * zz_s;
            den0_reg <= DEN_W'(C0S_DEN);
            num1_reg <= NUM_W'(10000) * zz_s - NUM_W'(C1S_SUB);
            den1_reg <= DEN_W'(C1S_DK) * r_d;
        end
    end

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= s2_side_reg;
        for (int i = 1; i < SIDE_LAT; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];
    end

    ikarm_div u_div0 (.clk(clk), .num(num0_reg), .den(den0_reg), .c(cos0));
    ikarm_div u_div1 (.clk(clk), .num(num1_reg), .den(den1_reg), .c(cos1));
    ikarm_div u_div2 (.clk(clk), .num(num2_reg), .den(den2_reg), .c(cos2));

    ikarm_acos u_acos0 (.clk(clk), .c(cos0), .ang(ang0));
    ikarm_acos u_acos1 (.clk(clk), .c(cos1), .ang(ang1));
    ikarm_acos u_acos2 (.clk(clk), .c(cos2), .ang(ang2));

    ikarm_pose u_pose (
        .side (side_dly_reg[SIDE_LAT-1]),
        .ang0 (ang0),
        .ang1 (ang1),
        .ang2 (ang2),
        .j1   (j1),
        .j2   (j2),
        .j3   (j3),
        .j4   (j4),
        .st   (st)
    );

    always_ff @(posedge clk)
    begin
        joint_one_reg   <= j1;
        joint_two_reg   <= j2;
        joint_three_reg <= j3;
        joint_four_reg  <= j4;
        status_reg      <= st;
    end

    assign done        = done_reg;
    assign joint_one   = joint_one_reg;
    assign joint_two   = joint_two_reg;
    assign joint_three = joint_three_reg;
    assign joint_four  = joint_four_reg;
    assign status      = status_reg;

endmodule
